/* rtl/core/assert_macros.svh */
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the grid stepper checkers
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every edge outside reset
`define FSG_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked on every edge, reset included
`define FSG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/core/fsg_pkg.sv */
// ---------------------------------------------------------------------------
// fsg_pkg
// types, codes and sizes shared by the falling sand grid stepper
// ---------------------------------------------------------------------------
package fsg_pkg;

  localparam int MAX_COLS  = 64;
  localparam int MAX_ROWS  = 64;
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int COL_CNT_W = $clog2(MAX_COLS + 1);
  localparam int ROW_CNT_W = $clog2(MAX_ROWS + 1);
  localparam int ADDR_W    = ROW_W + COL_W;
  localparam int DEPTH     = 1 << ADDR_W;

  localparam int FUNC_W      = 2;
  localparam int FIELD_COL_W = 6;
  localparam int FIELD_ROW_W = 6;
  localparam int KIND_W      = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int DIM_REG_W   = 7;
  localparam int SEED_W      = 16;

  localparam logic [FUNC_W-1:0] FUNC_SPAWN = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  localparam logic [KIND_W-1:0] KIND_AIR     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SAND    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_WATER   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_INVALID = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEED = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SP_CHK,
    ST_RD_CHK,
    ST_TK_HERE,
    ST_TK_BELOW,
    ST_TK_SIDE_TRY,
    ST_TK_SIDE_CHK,
    ST_TK_WR_TO,
    ST_TK_WR_FROM,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic [COL_CNT_W-1:0] cols;
    logic [ROW_CNT_W-1:0] rows;
    logic                 side;
  } cfg_view_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [KIND_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

/* rtl/core/fsg_cmd_if.sv */
// ---------------------------------------------------------------------------
// fsg_cmd_if
// command channel: spawn, tick or read of one cell
// ---------------------------------------------------------------------------
interface fsg_cmd_if
  import fsg_pkg::*;
  ();
  logic                   valid;
  logic                   ready;
  logic [FUNC_W-1:0]      func;
  logic [FIELD_COL_W-1:0] col;
  logic [FIELD_ROW_W-1:0] row;
  logic [KIND_W-1:0]      kind;

  modport source (output valid, func, col, row, kind, input ready);
  modport sink   (input valid, func, col, row, kind, output ready);
endinterface

/* rtl/core/fsg_rsp_if.sv */
// ---------------------------------------------------------------------------
// fsg_rsp_if
// response channel: one word per command
// ---------------------------------------------------------------------------
interface fsg_rsp_if
  import fsg_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              status;
  logic [KIND_W-1:0] cell_kind;

  modport source (output valid, status, cell_kind, input ready);
  modport sink   (input valid, status, cell_kind, output ready);
endinterface

/* rtl/core/fsg_cfg_if.sv */
// ---------------------------------------------------------------------------
// fsg_cfg_if
// configuration write channel
// ---------------------------------------------------------------------------
interface fsg_cfg_if
  import fsg_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/fsg_ram.sv */
// ---------------------------------------------------------------------------
// fsg_ram
// generic simple dual port ram, one write and one registered read port
// ---------------------------------------------------------------------------
module fsg_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/fsg_cfg.sv */
// ---------------------------------------------------------------------------
// fsg_cfg
// configuration registers, clamped grid size and side choice lfsr
// ---------------------------------------------------------------------------
module fsg_cfg
  import fsg_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  fsg_cfg_if.sink   cfg,
  input  logic      draw,
  output cfg_view_t view
);

  logic [DIM_REG_W-1:0] cols_reg;
  logic [DIM_REG_W-1:0] rows_reg;
  logic [SEED_W-1:0]    lfsr;
  logic [SEED_W-1:0]    seed_in;
  logic                 fb;

  assign cfg.ready = 1'b1;
  assign seed_in   = SEED_W'(cfg.data);
  assign fb        = lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5];

  always_ff @(posedge clk) begin
    if (rst) begin
      cols_reg <= DIM_REG_W'(MAX_COLS);
      rows_reg <= DIM_REG_W'(MAX_ROWS);
      lfsr     <= SEED_W'(1);
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_COLS: cols_reg <= DIM_REG_W'(cfg.data);
        REG_ROWS: rows_reg <= DIM_REG_W'(cfg.data);
        REG_SEED: lfsr <= (seed_in == '0) ? SEED_W'(1) : seed_in;
        default: ;
      endcase
    end else if (draw) begin
      lfsr <= {fb, lfsr[SEED_W-1:1]};
    end
  end

  always_comb begin
    if (cols_reg == '0) begin
      view.cols = COL_CNT_W'(1);
    end else if (32'(cols_reg) > MAX_COLS) begin
      view.cols = COL_CNT_W'(MAX_COLS);
    end else begin
      view.cols = COL_CNT_W'(cols_reg);
    end
    if (rows_reg == '0) begin
      view.rows = ROW_CNT_W'(1);
    end else if (32'(rows_reg) > MAX_ROWS) begin
      view.rows = ROW_CNT_W'(MAX_ROWS);
    end else begin
      view.rows = ROW_CNT_W'(rows_reg);
    end
    view.side = lfsr[0];
  end

endmodule

/* rtl/core/fsg_engine.sv */
// ---------------------------------------------------------------------------
// fsg_engine
// command sequencer: clear pass, spawn, read and the cell scan of a tick
// ---------------------------------------------------------------------------
module fsg_engine
  import fsg_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  fsg_cmd_if.sink           cmd,
  fsg_rsp_if.source         rsp,
  input  cfg_view_t         cfgv,
  output logic              draw,
  output ram_req_t          ram,
  input  logic [KIND_W-1:0] ram_rdata
);

  state_t                 state, state_next;
  logic [ADDR_W-1:0]      clr_addr, clr_addr_next;
  logic [FIELD_ROW_W-1:0] req_row, req_row_next;
  logic [FIELD_COL_W-1:0] req_col, req_col_next;
  logic [KIND_W-1:0]      req_kind, req_kind_next;
  logic [ROW_W-1:0]       cur_row, cur_row_next;
  logic [COL_W-1:0]       cur_col, cur_col_next;
  logic [KIND_W-1:0]      here_kind, here_kind_next;
  logic [KIND_W-1:0]      dst_kind, dst_kind_next;
  logic [ADDR_W-1:0]      dst_addr, dst_addr_next;
  logic                   first_left, first_left_next;
  logic                   attempt, attempt_next;
  logic                   down, down_next;
  logic                   pend_skip, pend_skip_next;
  logic                   skip, skip_next;
  logic                   res_status, res_status_next;
  logic [KIND_W-1:0]      res_kind, res_kind_next;
  logic                   rsp_valid, rsp_valid_next;
  logic                   rsp_status, rsp_status_next;
  logic [KIND_W-1:0]      rsp_kind, rsp_kind_next;

  logic              inb;
  logic [ADDR_W-1:0] req_addr;
  logic [ADDR_W-1:0] here_addr;
  logic [ADDR_W-1:0] below_addr;
  logic [ADDR_W-1:0] side_addr;
  logic              last_col;
  logic              has_below;
  logic              go_left;
  logic              can_go;
  logic              adv;
  logic              adv_skip;
  logic [ROW_W-1:0]  nxt_row;
  logic [COL_W-1:0]  nxt_col;
  logic [ROW_W-1:0]  top_row;

  assign inb = (32'(req_row) < 32'(cfgv.rows)) && (32'(req_col) < 32'(cfgv.cols));
  assign req_addr   = {ROW_W'(req_row), COL_W'(req_col)};
  assign here_addr  = {cur_row, cur_col};
  assign below_addr = {cur_row + ROW_W'(1), cur_col};
  assign last_col   = (COL_CNT_W'(cur_col) + COL_CNT_W'(1)) >= cfgv.cols;
  assign has_below  = (ROW_CNT_W'(cur_row) + ROW_CNT_W'(1)) < cfgv.rows;
  assign go_left    = attempt ? !first_left : first_left;
  assign can_go     = go_left ? (cur_col != '0) : !last_col;
  assign side_addr  = {cur_row + ROW_W'(down),
                       go_left ? cur_col - COL_W'(1) : cur_col + COL_W'(1)};
  assign nxt_row    = last_col ? cur_row - ROW_W'(1) : cur_row;
  assign nxt_col    = last_col ? '0 : cur_col + COL_W'(1);
  assign top_row    = ROW_W'(cfgv.rows - ROW_CNT_W'(1));

  assign rsp.valid     = rsp_valid;
  assign rsp.status    = rsp_status;
  assign rsp.cell_kind = rsp_kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      skip      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_addr  <= clr_addr_next;
      skip      <= skip_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    req_row    <= req_row_next;
    req_col    <= req_col_next;
    req_kind   <= req_kind_next;
    cur_row    <= cur_row_next;
    cur_col    <= cur_col_next;
    here_kind  <= here_kind_next;
    dst_kind   <= dst_kind_next;
    dst_addr   <= dst_addr_next;
    first_left <= first_left_next;
    attempt    <= attempt_next;
    down       <= down_next;
    pend_skip  <= pend_skip_next;
    res_status <= res_status_next;
    res_kind   <= res_kind_next;
    rsp_status <= rsp_status_next;
    rsp_kind   <= rsp_kind_next;
  end

  always_comb begin
    state_next      = state;
    clr_addr_next   = clr_addr;
    req_row_next    = req_row;
    req_col_next    = req_col;
    req_kind_next   = req_kind;
    cur_row_next    = cur_row;
    cur_col_next    = cur_col;
    here_kind_next  = here_kind;
    dst_kind_next   = dst_kind;
    dst_addr_next   = dst_addr;
    first_left_next = first_left;
    attempt_next    = attempt;
    down_next       = down;
    pend_skip_next  = pend_skip;
    skip_next       = skip;
    res_status_next = res_status;
    res_kind_next   = res_kind;
    rsp_valid_next  = rsp_valid;
    rsp_status_next = rsp_status;
    rsp_kind_next   = rsp_kind;
    cmd.ready       = 1'b0;
    draw            = 1'b0;
    ram.we          = 1'b0;
    ram.waddr       = here_addr;
    ram.wdata       = KIND_AIR;
    ram.raddr       = here_addr;
    adv             = 1'b0;
    adv_skip        = 1'b0;

    if (rsp_valid && rsp.ready) begin
      rsp_valid_next = 1'b0;
    end

    case (state)
      ST_CLEAR: begin
        ram.we        = 1'b1;
        ram.waddr     = clr_addr;
        ram.wdata     = KIND_AIR;
        clr_addr_next = clr_addr + ADDR_W'(1);
        if (clr_addr == ADDR_W'(DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cmd.ready     = 1'b1;
        req_row_next  = cmd.row;
        req_col_next  = cmd.col;
        req_kind_next = cmd.kind;
        ram.raddr     = {ROW_W'(cmd.row), COL_W'(cmd.col)};
        if (cmd.valid) begin
          case (cmd.func)
            FUNC_SPAWN: state_next = ST_SP_CHK;
            FUNC_READ:  state_next = ST_RD_CHK;
            FUNC_TICK: begin
              cur_row_next = top_row;
              cur_col_next = '0;
              skip_next    = 1'b0;
              ram.raddr    = {top_row, COL_W'(0)};
              state_next   = ST_TK_HERE;
            end
            default: begin
              res_status_next = 1'b0;
              res_kind_next   = KIND_AIR;
              state_next      = ST_RESULT;
            end
          endcase
        end
      end
      ST_SP_CHK: begin
        res_kind_next = KIND_AIR;
        if (!inb || req_kind == KIND_INVALID || ram_rdata != KIND_AIR) begin
          res_status_next = 1'b1;
        end else begin
          res_status_next = 1'b0;
          ram.we          = 1'b1;
          ram.waddr       = req_addr;
          ram.wdata       = req_kind;
        end
        state_next = ST_RESULT;
      end
      ST_RD_CHK: begin
        res_status_next = 1'b0;
        res_kind_next   = inb ? ram_rdata : KIND_AIR;
        state_next      = ST_RESULT;
      end
      ST_TK_HERE: begin
        here_kind_next = ram_rdata;
        if (skip || ram_rdata == KIND_AIR || ram_rdata == KIND_INVALID) begin
          adv = 1'b1;
        end else if (has_below) begin
          ram.raddr  = below_addr;
          state_next = ST_TK_BELOW;
        end else if (ram_rdata == KIND_WATER) begin
          draw            = 1'b1;
          first_left_next = !cfgv.side;
          attempt_next    = 1'b0;
          down_next       = 1'b0;
          state_next      = ST_TK_SIDE_TRY;
        end else begin
          adv = 1'b1;
        end
      end
      ST_TK_BELOW: begin
        if (ram_rdata == KIND_AIR ||
            (here_kind == KIND_SAND && ram_rdata == KIND_WATER)) begin
          dst_addr_next  = below_addr;
          dst_kind_next  = ram_rdata;
          pend_skip_next = 1'b0;
          state_next     = ST_TK_WR_TO;
        end else if (here_kind == KIND_WATER ||
                     (here_kind == KIND_SAND && ram_rdata == KIND_SAND)) begin
          draw            = 1'b1;
          first_left_next = !cfgv.side;
          attempt_next    = 1'b0;
          down_next       = (here_kind == KIND_SAND);
          state_next      = ST_TK_SIDE_TRY;
        end else begin
          adv = 1'b1;
        end
      end
      ST_TK_SIDE_TRY: begin
        if (can_go) begin
          ram.raddr      = side_addr;
          dst_addr_next  = side_addr;
          pend_skip_next = !down && !go_left;
          state_next     = ST_TK_SIDE_CHK;
        end else if (!attempt) begin
          attempt_next = 1'b1;
        end else begin
          adv = 1'b1;
        end
      end
      ST_TK_SIDE_CHK: begin
        if (ram_rdata == KIND_AIR || (down && ram_rdata == KIND_WATER)) begin
          dst_kind_next = ram_rdata;
          state_next    = ST_TK_WR_TO;
        end else if (!attempt) begin
          attempt_next = 1'b1;
          state_next   = ST_TK_SIDE_TRY;
        end else begin
          adv = 1'b1;
        end
      end
      ST_TK_WR_TO: begin
        ram.we     = 1'b1;
        ram.waddr  = dst_addr;
        ram.wdata  = here_kind;
        state_next = ST_TK_WR_FROM;
      end
      ST_TK_WR_FROM: begin
        ram.we    = 1'b1;
        ram.waddr = here_addr;
        ram.wdata = dst_kind;
        adv       = 1'b1;
        adv_skip  = pend_skip;
      end
      ST_RESULT: begin
        if (!rsp_valid || rsp.ready) begin
          rsp_valid_next  = 1'b1;
          rsp_status_next = res_status;
          rsp_kind_next   = res_kind;
          state_next      = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase

    // step to the next cell of the scan, or finish the tick
    if (adv) begin
      if (last_col && cur_row == '0) begin
        res_status_next = 1'b0;
        res_kind_next   = KIND_AIR;
        skip_next       = 1'b0;
        state_next      = ST_RESULT;
      end else begin
        cur_row_next = nxt_row;
        cur_col_next = nxt_col;
        skip_next    = adv_skip;
        ram.raddr    = {nxt_row, nxt_col};
        state_next   = ST_TK_HERE;
      end
    end
  end

endmodule

/* rtl/core/falling_sand_grid_step.sv */
// ---------------------------------------------------------------------------
// falling_sand_grid_step
// grid of air, sand and water cells advanced one tick per tick command
// ---------------------------------------------------------------------------
// channels: cmd takes one word per command (func, col, row, kind), rsp
// returns one word per command (status, cell_kind), cfg writes the
// grid_cols, grid_rows and random_seed registers and is always ready.
// after reset the grid memory is swept to air, one entry a cycle over all
// 4096 entries, with cmd.ready low; cfg writes are taken during the sweep.
// spawn and read: the command is accepted while its cell is read, then
// checked, and then its result is loaded into the rsp register.
// tick: the used area is scanned from the bottom row up, left to right;
// air and skipped cells are passed over, sand or water reads the cell below
// if any and may try the sides, and a move writes its destination and then
// its source; the grid memory has a single read port.
// cmd is taken once the previous result sits in the rsp register, so a
// stalled receiver holds at most one word and delays only the next result.
// ---------------------------------------------------------------------------
module falling_sand_grid_step
  import fsg_pkg::*;
(
  input logic       clk,
  input logic       rst,
  fsg_cmd_if.sink   cmd,
  fsg_rsp_if.source rsp,
  fsg_cfg_if.sink   cfg
);

  cfg_view_t         cfgv;
  ram_req_t          ram;
  logic              draw;
  logic [KIND_W-1:0] ram_rdata;

  fsg_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .draw (draw),
    .view (cfgv)
  );

  fsg_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .rsp       (rsp),
    .cfgv      (cfgv),
    .draw      (draw),
    .ram       (ram),
    .ram_rdata (ram_rdata)
  );

  fsg_ram #(
    .WIDTH (KIND_W),
    .DEPTH (DEPTH)
  ) u_grid (
    .clk   (clk),
    .we    (ram.we),
    .waddr (ram.waddr),
    .wdata (ram.wdata),
    .raddr (ram.raddr),
    .rdata (ram_rdata)
  );

endmodule

/* rtl/core/fsg_checker.sv */
// ---------------------------------------------------------------------------
// fsg_checker
// port level checks of the grid stepper, bound to the top level
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fsg_checker
  import fsg_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              cmd_valid,
  input logic              cmd_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic              rsp_status,
  input logic [KIND_W-1:0] rsp_cell_kind
);

  logic [KIND_W:0] rsp_word;
  logic            rsp_bad;

  assign rsp_word = {rsp_status, rsp_cell_kind};
  assign rsp_bad  = (rsp_cell_kind == KIND_INVALID) ||
                    (rsp_status && (rsp_cell_kind != KIND_AIR));

  `FSG_ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> (!rsp_valid && !cmd_ready), "busy after reset")
  `FSG_ASSERT(a_one_at_a_time, clk, rst, (cmd_valid && cmd_ready) |=> !cmd_ready, "cmd while busy")
  `FSG_ASSERT(a_rsp_hold, clk, rst, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_word)), "rsp word changed")
  `FSG_ASSERT(a_rsp_legal, clk, rst, rsp_valid |-> !rsp_bad, "illegal rsp word")

endmodule

bind falling_sand_grid_step fsg_checker u_fsg_checker (
  .clk           (clk),
  .rst           (rst),
  .cmd_valid     (cmd.valid),
  .cmd_ready     (cmd.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_status    (rsp.status),
  .rsp_cell_kind (rsp.cell_kind)
);

/* sim/falling_sand_grid_step_tb.sv */
// ---------------------------------------------------------------------------
// falling_sand_grid_step_tb
// drives spawn, tick, read and unused function words into the grid stepper under several
// grid sizes and seeds, keeps its own copy of the grid and the side lfsr,
// and checks every response word against the predicted status and kind
// ---------------------------------------------------------------------------
module falling_sand_grid_step_tb;
  import fsg_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;
  localparam int IDLE_PCT       = 29;
  localparam int QUIET_LO       = 40;
  localparam int QUIET_HI       = 80;
  localparam int SETTLE_CYCLES  = 8;
  localparam int TAIL_CYCLES    = 20;
  localparam int TIMEOUT_CYCLES = 5_000_000;
  localparam int NUM_PHASES     = 9;

  typedef enum logic [1:0] {OP_CMD, OP_CFG, OP_DRAIN} op_kind_t;

  typedef struct {
    op_kind_t               kind;
    logic [FUNC_W-1:0]      func;
    logic [FIELD_COL_W-1:0] col;
    logic [FIELD_ROW_W-1:0] row;
    logic [KIND_W-1:0]      particle;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  data;
  } pending_op_t;

  typedef struct {
    logic              status;
    logic [KIND_W-1:0] cell_kind;
  } rsp_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   cmd_valid = 1'b0;
  logic [FUNC_W-1:0]      cmd_func  = FUNC_SPAWN;
  logic [FIELD_COL_W-1:0] cmd_col   = '0;
  logic [FIELD_ROW_W-1:0] cmd_row   = '0;
  logic [KIND_W-1:0]      cmd_kind  = KIND_AIR;
  logic                   cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = REG_COLS;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;
  logic                   rsp_ready = 1'b0;

  fsg_cmd_if cmd_ch ();
  fsg_rsp_if rsp_ch ();
  fsg_cfg_if cfg_ch ();

  assign cmd_ch.valid = cmd_valid;
  assign cmd_ch.func  = cmd_func;
  assign cmd_ch.col   = cmd_col;
  assign cmd_ch.row   = cmd_row;
  assign cmd_ch.kind  = cmd_kind;
  assign cfg_ch.valid = cfg_valid;
  assign cfg_ch.index = cfg_index;
  assign cfg_ch.data  = cfg_data;
  assign rsp_ch.ready = rsp_ready;

  falling_sand_grid_step dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // predicted grid and registers
  logic [KIND_W-1:0]    grid_kind  [DEPTH];
  bit                   grid_moved [DEPTH];
  logic [DIM_REG_W-1:0] cols_reg;
  logic [DIM_REG_W-1:0] rows_reg;
  logic [SEED_W-1:0]    side_lfsr;

  pending_op_t pending_ops[$];
  rsp_word_t   expected_rsp[$];
  pending_op_t cmd_in_flight;
  int unsigned sent_cnt = 0;
  int unsigned got_cnt = 0;
  int          mismatches = 0;
  int          hold_cnt = 0;

  function automatic int dim_in_use(logic [DIM_REG_W-1:0] v, int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return int'(v);
  endfunction

  function automatic bit draw_side();
    bit shifted;
    bit fb;
    shifted = side_lfsr[0];
    fb = side_lfsr[0] ^ side_lfsr[2] ^ side_lfsr[3] ^ side_lfsr[5];
    side_lfsr = {fb, side_lfsr[15:1]};
    return shifted;
  endfunction

  function automatic void swap_into(int src, int dst);
    logic [KIND_W-1:0] mover;
    mover = grid_kind[src];
    grid_kind[src] = grid_kind[dst];
    grid_kind[dst] = mover;
    grid_moved[src] = 1'b1;
    grid_moved[dst] = 1'b1;
  endfunction

  function automatic bit try_sides(int r, int c, int cols, int down, bit water_ok);
    bit first_left;
    bit go_left;
    int nc;
    int dst;
    logic [KIND_W-1:0] k;
    first_left = (draw_side() == 1'b0);
    for (int a = 0; a < 2; a++) begin
      go_left = (a == 0) ? first_left : !first_left;
      if (go_left) begin
        if (c == 0) continue;
        nc = c - 1;
      end else begin
        if (c + 1 >= cols) continue;
        nc = c + 1;
      end
      dst = (r + down) * MAX_COLS + nc;
      k = grid_kind[dst];
      if (k == KIND_AIR || (water_ok && k == KIND_WATER)) begin
        swap_into(r * MAX_COLS + c, dst);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void settle_cell(int r, int c, int rows, int cols);
    int here;
    int below;
    logic [KIND_W-1:0] k;
    logic [KIND_W-1:0] bk;
    bit has_below;
    here = r * MAX_COLS + c;
    below = here + MAX_COLS;
    k = grid_kind[here];
    has_below = (r + 1 < rows);
    if (grid_moved[here] || k == KIND_AIR) return;
    if (k == KIND_SAND) begin
      if (has_below) begin
        bk = grid_kind[below];
        if (bk == KIND_AIR || bk == KIND_WATER) begin
          swap_into(here, below);
          return;
        end
        if (bk == KIND_SAND && try_sides(r, c, cols, 1, 1'b1)) return;
      end
    end else if (k == KIND_WATER) begin
      if (has_below && grid_kind[below] == KIND_AIR) begin
        swap_into(here, below);
        return;
      end
      if (try_sides(r, c, cols, 0, 1'b0)) return;
    end
    grid_moved[here] = 1'b1;
  endfunction

  function automatic void run_tick();
    int rows;
    int cols;
    rows = dim_in_use(rows_reg, MAX_ROWS);
    cols = dim_in_use(cols_reg, MAX_COLS);
    foreach (grid_moved[i]) grid_moved[i] = 1'b0;
    for (int r = rows - 1; r >= 0; r--)
      for (int c = 0; c < cols; c++)
        settle_cell(r, c, rows, cols);
  endfunction

  function automatic rsp_word_t grid_response(pending_op_t op);
    rsp_word_t w;
    int rows;
    int cols;
    bit inb;
    int addr;
    w.status = 1'b0;
    w.cell_kind = KIND_AIR;
    rows = dim_in_use(rows_reg, MAX_ROWS);
    cols = dim_in_use(cols_reg, MAX_COLS);
    inb = (int'(op.row) < rows) && (int'(op.col) < cols);
    addr = int'(op.row) * MAX_COLS + int'(op.col);
    case (op.func)
      FUNC_SPAWN: begin
        if (!inb || op.particle == KIND_INVALID || grid_kind[addr] != KIND_AIR)
          w.status = 1'b1;
        else
          grid_kind[addr] = op.particle;
      end
      FUNC_TICK: run_tick();
      FUNC_READ: begin
        if (inb) w.cell_kind = grid_kind[addr];
      end
      default: ;
    endcase
    return w;
  endfunction

  function automatic void write_register(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_COLS: cols_reg = data[DIM_REG_W-1:0];
      REG_ROWS: rows_reg = data[DIM_REG_W-1:0];
      REG_SEED: side_lfsr = (data == 0) ? SEED_W'(1) : data[SEED_W-1:0];
      default: ;
    endcase
  endfunction

  initial forever #4 clk = ~clk;

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    #(8 * TIMEOUT_CYCLES);
    $display("simulation failed");
    $finish;
  end

  // driver
  always @(posedge clk) begin
    pending_op_t op;
    bit cmd_taken;
    bit cfg_taken;
    bit nv_cmd;
    bit nv_cfg;
    bit quiet_send;
    cmd_taken = cmd_valid && cmd_ch.ready;
    cfg_taken = cfg_valid && cfg_ch.ready;
    nv_cmd = cmd_valid && !cmd_taken;
    nv_cfg = cfg_valid && !cfg_taken;
    quiet_send = (sent_cnt >= QUIET_LO) && (sent_cnt < QUIET_HI);
    if (rst) begin
      nv_cmd = 1'b0;
      nv_cfg = 1'b0;
      hold_cnt = 0;
      cols_reg = DIM_REG_W'(MAX_COLS);
      rows_reg = DIM_REG_W'(MAX_ROWS);
      side_lfsr = SEED_W'(1);
      foreach (grid_kind[i]) begin
        grid_kind[i] = KIND_AIR;
        grid_moved[i] = 1'b0;
      end
    end else begin
      if (cmd_taken) begin
        expected_rsp.push_back(grid_response(cmd_in_flight));
        sent_cnt <= sent_cnt + 1;
      end
      if (cfg_taken) write_register(cfg_index, cfg_data);
      if (!nv_cmd && !nv_cfg && pending_ops.size() > 0) begin
        if (hold_cnt > 0) begin
          hold_cnt--;
        end else begin
          op = pending_ops[0];
          case (op.kind)
            OP_CMD: begin
              if (quiet_send || $urandom_range(99) >= IDLE_PCT) begin
                cmd_func <= op.func;
                cmd_col <= op.col;
                cmd_row <= op.row;
                cmd_kind <= op.particle;
                cmd_in_flight = op;
                nv_cmd = 1'b1;
                void'(pending_ops.pop_front());
              end
            end
            OP_CFG: begin
              cfg_index <= op.idx;
              cfg_data <= op.data;
              nv_cfg = 1'b1;
              void'(pending_ops.pop_front());
            end
            default: begin
              // wait for all words back, then let the block settle
              if (!cmd_taken && sent_cnt == got_cnt) begin
                hold_cnt = SETTLE_CYCLES;
                void'(pending_ops.pop_front());
              end
            end
          endcase
        end
      end
    end
    cmd_valid <= nv_cmd;
    cfg_valid <= nv_cfg;
  end

  // monitor
  always @(posedge clk) begin
    rsp_word_t want;
    bit quiet_recv;
    quiet_recv = (got_cnt >= QUIET_LO) && (got_cnt < QUIET_HI);
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_ready && rsp_ch.valid) begin
        if (got_cnt == sent_cnt) begin
          $display("%0t: unexpected word, expected none, got status %0d cell_kind %0d",
                   $time, rsp_ch.status, rsp_ch.cell_kind);
          mismatches++;
        end else begin
          want = expected_rsp.pop_front();
          if (rsp_ch.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, rsp_ch.status);
            mismatches++;
          end
          if (rsp_ch.cell_kind !== want.cell_kind) begin
            $display("%0t: cell_kind mismatch, expected %0d, got %0d",
                     $time, want.cell_kind, rsp_ch.cell_kind);
            mismatches++;
          end
          got_cnt <= got_cnt + 1;
        end
      end
      rsp_ready <= quiet_recv || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic push_cmd(logic [FUNC_W-1:0] f, int c, int r, logic [KIND_W-1:0] k);
    pending_op_t op;
    op.kind = OP_CMD;
    op.func = f;
    op.col = FIELD_COL_W'(c);
    op.row = FIELD_ROW_W'(r);
    op.particle = k;
    op.idx = REG_COLS;
    op.data = '0;
    pending_ops.push_back(op);
  endtask

  task automatic push_cfg(logic [CFG_IDX_W-1:0] i, logic [CFG_DATA_W-1:0] d);
    pending_op_t op;
    op.kind = OP_CFG;
    op.func = FUNC_NOP;
    op.col = '0;
    op.row = '0;
    op.particle = KIND_AIR;
    op.idx = i;
    op.data = d;
    pending_ops.push_back(op);
  endtask

  task automatic push_drain();
    pending_op_t op;
    op.kind = OP_DRAIN;
    op.func = FUNC_NOP;
    op.col = '0;
    op.row = '0;
    op.particle = KIND_AIR;
    op.idx = REG_COLS;
    op.data = '0;
    pending_ops.push_back(op);
  endtask

  task automatic set_grid(logic [CFG_DATA_W-1:0] cols, logic [CFG_DATA_W-1:0] rows,
                          logic [CFG_DATA_W-1:0] seed);
    push_drain();
    push_cfg(REG_COLS, cols);
    push_cfg(REG_ROWS, rows);
    push_cfg(REG_SEED, seed);
  endtask

  // mostly spawns, ticks and in-bounds reads, with some fully random words
  task automatic random_batch(int n, int cols, int rows, int max_ticks);
    int p;
    int ticks;
    logic [KIND_W-1:0] k;
    ticks = 0;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(99);
      if (p < 35) begin
        k = ($urandom_range(9) == 0) ? KIND_AIR :
            ($urandom_range(1) == 0) ? KIND_SAND : KIND_WATER;
        push_cmd(FUNC_SPAWN, $urandom_range(cols - 1), $urandom_range(rows - 1), k);
      end else if (p < 55 && ticks < max_ticks) begin
        push_cmd(FUNC_TICK, $urandom_range(63), $urandom_range(63),
                 KIND_W'($urandom_range(3)));
        ticks++;
      end else if (p < 85) begin
        push_cmd(FUNC_READ, $urandom_range(cols - 1), $urandom_range(rows - 1),
                 KIND_W'($urandom_range(3)));
      end else begin
        push_cmd(FUNC_W'($urandom_range(3)), $urandom_range(63), $urandom_range(63),
                 KIND_W'($urandom_range(3)));
      end
    end
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] phase_cols [NUM_PHASES];
    logic [CFG_DATA_W-1:0] phase_rows [NUM_PHASES];
    logic [CFG_DATA_W-1:0] seed;
    int max_ticks;

    phase_cols = '{16'd1, 16'd0, 16'd2, 16'd8, 16'hFF85, 16'd127, 16'd4, 16'd3, 16'd64};
    phase_rows = '{16'd1, 16'd0, 16'd8, 16'd2, 16'd6, 16'd3, 16'd100, 16'd4, 16'd64};

    // default 64 by 64 grid after reset
    push_cmd(FUNC_READ, 0, 0, KIND_AIR);
    push_cmd(FUNC_SPAWN, 63, 63, KIND_SAND);
    push_cmd(FUNC_SPAWN, 0, 0, KIND_WATER);
    push_cmd(FUNC_SPAWN, 63, 0, KIND_SAND);
    push_cmd(FUNC_SPAWN, 63, 63, KIND_WATER);
    push_cmd(FUNC_SPAWN, 5, 5, KIND_INVALID);
    push_cmd(FUNC_SPAWN, 10, 10, KIND_AIR);
    push_cmd(FUNC_NOP, 63, 63, KIND_INVALID);
    push_cmd(FUNC_READ, 63, 63, KIND_INVALID);
    push_cmd(FUNC_TICK, 0, 0, KIND_AIR);
    push_cmd(FUNC_READ, 0, 1, KIND_AIR);
    push_cmd(FUNC_READ, 63, 1, KIND_AIR);

    // 4 by 4 grid, zero seed; old content stays outside the used area
    set_grid(16'd4, 16'd4, 16'd0);
    push_cmd(FUNC_SPAWN, 1, 3, KIND_SAND);
    push_cmd(FUNC_SPAWN, 1, 2, KIND_SAND);
    push_cmd(FUNC_SPAWN, 2, 3, KIND_WATER);
    push_cmd(FUNC_SPAWN, 2, 2, KIND_SAND);
    push_cmd(FUNC_SPAWN, 3, 3, KIND_WATER);
    push_cmd(FUNC_SPAWN, 0, 0, KIND_WATER);
    push_cmd(FUNC_SPAWN, 4, 0, KIND_SAND);
    push_cmd(FUNC_READ, 63, 63, KIND_AIR);
    push_cmd(FUNC_TICK, 0, 0, KIND_AIR);
    push_cmd(FUNC_TICK, 0, 0, KIND_AIR);
    push_cmd(FUNC_READ, 0, 3, KIND_AIR);
    push_cmd(FUNC_READ, 2, 3, KIND_AIR);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      seed = (ph == 0) ? 16'hFFFF : CFG_DATA_W'($urandom_range(65535, 1));
      set_grid(phase_cols[ph], phase_rows[ph], seed);
      max_ticks = (ph == NUM_PHASES - 1) ? 2 : 100;
      random_batch((ph == NUM_PHASES - 1) ? 12 : 8,
                   dim_in_use(phase_cols[ph][DIM_REG_W-1:0], MAX_COLS),
                   dim_in_use(phase_rows[ph][DIM_REG_W-1:0], MAX_ROWS), max_ticks);
    end
    push_drain();

    @(negedge clk);
    while (rst || pending_ops.size() != 0 || cmd_valid || cfg_valid || sent_cnt != got_cnt)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && sent_cnt == got_cnt) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/fsg_pkg.sv
rtl/core/fsg_cmd_if.sv
rtl/core/fsg_rsp_if.sv
rtl/core/fsg_cfg_if.sv
rtl/core/fsg_ram.sv
rtl/core/fsg_cfg.sv
rtl/core/fsg_engine.sv
rtl/core/falling_sand_grid_step.sv
rtl/core/fsg_checker.sv
sim/falling_sand_grid_step_tb.sv
